/* sv/haptic_alarm_pattern_sequencer_macros.svh */
// assertion macros for the haptic alarm pattern sequencer
`ifndef HAPTIC_ALARM_PATTERN_SEQUENCER_MACROS_SVH
`define HAPTIC_ALARM_PATTERN_SEQUENCER_MACROS_SVH

// same-cycle implication, checked outside reset
`define HAPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define HAPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/haps_pkg.sv */
// shared types, codes and pattern tables of the haptic alarm pattern sequencer
package haps_pkg;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_TRIGGER = 2'd1,
    OP_ACK     = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    REG_DUTY_DRIFT    = 2'd0,
    REG_DUTY_NEAR     = 2'd1,
    REG_DUTY_CRITICAL = 2'd2,
    REG_TICK_MS       = 2'd3
  } reg_idx_t;

  localparam logic [1:0] LVL_NONE     = 2'd0;
  localparam logic [1:0] LVL_DRIFT    = 2'd1;
  localparam logic [1:0] LVL_NEAR     = 2'd2;
  localparam logic [1:0] LVL_CRITICAL = 2'd3;

  localparam logic [8:0] DUTY_DRIFT_RST    = 9'd249;
  localparam logic [8:0] DUTY_NEAR_RST     = 9'd374;
  localparam logic [8:0] DUTY_CRITICAL_RST = 9'd494;
  localparam logic [6:0] TICK_MS_RST       = 7'd5;

  // step duration in ms for a level and step
  function automatic logic [9:0] step_ms(input logic [1:0] level, input logic [2:0] idx);
    logic [9:0] ms;
    ms = '0;
    case (level)
      LVL_DRIFT: begin
        case (idx)
          3'd0:    ms = 10'd200;
          3'd1:    ms = 10'd800;
          default: ms = '0;
        endcase
      end
      LVL_NEAR: begin
        case (idx)
          3'd0, 3'd1, 3'd2: ms = 10'd150;
          3'd3:             ms = 10'd550;
          default:          ms = '0;
        endcase
      end
      LVL_CRITICAL: begin
        case (idx)
          3'd0, 3'd1, 3'd2, 3'd3, 3'd4: ms = 10'd100;
          3'd5:                         ms = 10'd500;
          default:                      ms = '0;
        endcase
      end
      default: ms = '0;
    endcase
    return ms;
  endfunction

  // even steps run the motor, odd steps are pauses
  function automatic logic step_on(input logic [1:0] level, input logic [2:0] idx);
    logic on;
    on = 1'b0;
    case (level)
      LVL_DRIFT:    on = (idx == 3'd0);
      LVL_NEAR:     on = (idx == 3'd0) || (idx == 3'd2);
      LVL_CRITICAL: on = (idx == 3'd0) || (idx == 3'd2) || (idx == 3'd4);
      default:      on = 1'b0;
    endcase
    return on;
  endfunction

  function automatic logic [2:0] pattern_len(input logic [1:0] level);
    logic [2:0] len;
    case (level)
      LVL_DRIFT:    len = 3'd2;
      LVL_NEAR:     len = 3'd4;
      LVL_CRITICAL: len = 3'd6;
      default:      len = 3'd0;
    endcase
    return len;
  endfunction

endpackage

/* sv/haptic_alarm_pattern_sequencer.sv */
// haptic alarm pattern sequencer: event-driven motor pattern player with apb registers
// the result of an accepted beat is registered; the master side sees it the next cycle
// throughput: one beat per cycle, m_tready permitting; result register frees when taken
// the pattern state update and the result are computed in one pass from the input beat
// reset (rst, synchronous, active high) clears level, snooze, step, time and motor,
// empties the result register and reloads the duty and tick registers with defaults
`include "haptic_alarm_pattern_sequencer_macros.svh"

module haptic_alarm_pattern_sequencer
  import haps_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [1:0] alarm_level, [7:2] zero
  input  logic [1:0]  s_tuser,   // [1:0] opcode
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [0] motor_run, [9:1] pwm_compare, [10] pattern_active,
                                 // [12:11] playing_level, [15:13] zero
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [8:0] duty_drift;
  logic [8:0] duty_near;
  logic [8:0] duty_critical;
  logic [6:0] tick_ms;

  logic [1:0] current_level, current_level_next;
  logic [1:0] snoozed_level, snoozed_level_next;
  logic [2:0] step_index, step_index_next;
  logic [9:0] remaining_ms, remaining_ms_next;
  logic       motor_running, motor_running_next;

  logic        out_valid;
  logic [15:0] out_data;
  logic [15:0] out_data_next;

  logic       accept;
  logic       cfg_write;
  reg_idx_t   cfg_idx;
  op_t        op;
  logic [1:0] lvl;
  logic       finished;
  logic [2:0] step_inc;
  logic       active_next;
  logic [8:0] duty_sel;
  logic [8:0] pwm_next;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_idx   = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      duty_drift    <= DUTY_DRIFT_RST;
      duty_near     <= DUTY_NEAR_RST;
      duty_critical <= DUTY_CRITICAL_RST;
      tick_ms       <= TICK_MS_RST;
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_DUTY_DRIFT:    duty_drift    <= pwdata[8:0];
        REG_DUTY_NEAR:     duty_near     <= pwdata[8:0];
        REG_DUTY_CRITICAL: duty_critical <= pwdata[8:0];
        REG_TICK_MS:       tick_ms       <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      REG_DUTY_DRIFT:    prdata = {23'd0, duty_drift};
      REG_DUTY_NEAR:     prdata = {23'd0, duty_near};
      REG_DUTY_CRITICAL: prdata = {23'd0, duty_critical};
      REG_TICK_MS:       prdata = {25'd0, tick_ms};
      default:           prdata = '0;
    endcase
  end

  assign s_tready = !out_valid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign op       = op_t'(s_tuser);
  assign lvl      = s_tdata[1:0];
  assign finished = (step_index >= pattern_len(current_level));
  assign step_inc = step_index + 3'd1;

  always_comb begin
    current_level_next = current_level;
    snoozed_level_next = snoozed_level;
    step_index_next    = step_index;
    remaining_ms_next  = remaining_ms;
    motor_running_next = motor_running;
    case (op)
      OP_TICK: begin
        if (current_level != LVL_NONE && !finished) begin
          if (remaining_ms > {3'd0, tick_ms}) begin
            remaining_ms_next = remaining_ms - {3'd0, tick_ms};
          end else begin
            step_index_next = step_inc;
            if (step_inc >= pattern_len(current_level)) begin
              motor_running_next = 1'b0;
            end else begin
              remaining_ms_next  = step_ms(current_level, step_inc);
              motor_running_next = step_on(current_level, step_inc);
            end
          end
        end
      end
      OP_TRIGGER: begin
        if (lvl == LVL_NONE) begin
          snoozed_level_next = LVL_NONE;
          current_level_next = LVL_NONE;
          step_index_next    = '0;
          remaining_ms_next  = '0;
          motor_running_next = 1'b0;
        end else if (lvl == snoozed_level) begin
          // silenced at this level
        end else if (lvl != current_level || finished) begin
          if (lvl != current_level) begin
            snoozed_level_next = LVL_NONE;
          end
          current_level_next = lvl;
          step_index_next    = '0;
          remaining_ms_next  = step_ms(lvl, 3'd0);
          motor_running_next = step_on(lvl, 3'd0);
        end
      end
      OP_ACK: begin
        snoozed_level_next = current_level;
        current_level_next = LVL_NONE;
        step_index_next    = '0;
        remaining_ms_next  = '0;
        motor_running_next = 1'b0;
      end
      default: ;
    endcase
  end

  always_comb begin
    case (current_level_next)
      LVL_DRIFT:    duty_sel = duty_drift;
      LVL_NEAR:     duty_sel = duty_near;
      LVL_CRITICAL: duty_sel = duty_critical;
      default:      duty_sel = '0;
    endcase
  end

  assign pwm_next    = motor_running_next ? duty_sel : 9'd0;
  assign active_next = (current_level_next != LVL_NONE) &&
                       (step_index_next < pattern_len(current_level_next));
  assign out_data_next = {3'd0, current_level_next, active_next, pwm_next,
                          motor_running_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      current_level <= LVL_NONE;
      snoozed_level <= LVL_NONE;
      step_index    <= '0;
      remaining_ms  <= '0;
      motor_running <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (accept) begin
        current_level <= current_level_next;
        snoozed_level <= snoozed_level_next;
        step_index    <= step_index_next;
        remaining_ms  <= remaining_ms_next;
        motor_running <= motor_running_next;
        out_valid     <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= out_data_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  `HAPS_ASSERT_NOW(a_motor_needs_level, motor_running, current_level != LVL_NONE, "motor runs with no level")
  `HAPS_ASSERT_NOW(a_snooze_excludes_play, snoozed_level != LVL_NONE, current_level == LVL_NONE, "snoozed while a level plays")
  `HAPS_ASSERT_NOW(a_motor_within_pattern, motor_running, !finished, "motor runs past the pattern end")
  `HAPS_ASSERT_NEXT(a_idle_tick_holds, accept && op == OP_TICK && (current_level == LVL_NONE || finished), $stable(step_index) && $stable(remaining_ms) && $stable(motor_running), "tick changed an idle pattern")

endmodule
